FILE: rtl/rdfc_pkg.sv
// shared constants, types and codes for the rest detector and face classifier
// no dependencies; every rtl file refers to this package by scoped names
`timescale 1ns / 1ps

package rdfc_pkg;

  localparam int MAX_FACES   = 8;
  localparam int HISTORY_LEN = 4;

  // field widths
  localparam int VEC_W      = 16;
  localparam int SLOT_W     = 3;
  localparam int BOUND_W    = 32;
  localparam int FACE_CNT_W = 4;
  localparam int FACE_NUM_W = 4;
  localparam int CFG_IDX_W  = 2;

  // serial multiply-accumulate widths
  localparam int P_W       = VEC_W + 2;      // sum of three selected components
  localparam int ACC_W     = P_W + 2;        // running upper part with headroom
  localparam int LO_W      = VEC_W - 1;      // low product bits shifted out
  localparam int DOT_W     = ACC_W + LO_W;
  localparam int BIT_CNT_W = $clog2(VEC_W);

  // face scan
  localparam int SCAN_CNT_W = $clog2(MAX_FACES + 1);
  localparam int FACE_IDX_W = $clog2(MAX_FACES);

  // reset values of the configuration registers
  localparam logic [BOUND_W-1:0]    REST_LOW_RST   = 32'd1310720;
  localparam logic [BOUND_W-1:0]    REST_HIGH_RST  = 32'd1966080;
  localparam logic [FACE_CNT_W-1:0] FACE_COUNT_RST = 4'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT = 2'd2;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FACE   = 1'b1;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec3_t;

  // control for the dot product lanes
  typedef struct packed {
    logic en;
    logic first;
    logic last;
  } lane_ctl_t;

  // control for the rest check and face search
  typedef struct packed {
    logic                  clear;
    logic                  en;
    logic                  active;
    logic [SCAN_CNT_W-1:0] idx;
  } dec_ctl_t;

endpackage

FILE: rtl/rest_detect_face_classifier_core.sv
// top level of the rest detector and face classifier: control, history, face table
// depends on rdfc_pkg, rdfc_dot_lane and rdfc_decide
`timescale 1ns / 1ps

// usage
//  input channel (in_valid / in_stall): one transaction per item. kind 0 is an
//  accelerometer sample and yields exactly one result; kind 1 stores a face
//  vector in slot face_slot and yields nothing.
//  result channel (out_valid / out_stall): came_to_rest and face_number, held
//  in an output register until taken.
//  config channel (cfg_valid / cfg_ready): index 0 lower rest bound, 1 upper
//  rest bound, 2 face count; cfg_ready is always high.
//  timing: a sample is accepted, then runs a bit-serial multiply (one sample
//  bit per cycle in every dot product lane), a face search over the first n
//  table entries, where n is the face count saturated to the table size, and
//  a result write. a face item is written to the table when accepted. one
//  item is in work at a time; the next is accepted while the previous result
//  still waits in the output reg. a stalled receiver holds the result; a
//  finished sample then waits until the output register frees up.
//  reset clears the history to zero, the motion flag and the registers to
//  their defaults; face entries are undefined until written.

module rest_detect_face_classifier_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic signed [rdfc_pkg::VEC_W-1:0]   in_vec_x,
  input  logic signed [rdfc_pkg::VEC_W-1:0]   in_vec_y,
  input  logic signed [rdfc_pkg::VEC_W-1:0]   in_vec_z,
  input  logic [rdfc_pkg::SLOT_W-1:0]         in_face_slot,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_came_to_rest,
  output logic [rdfc_pkg::FACE_NUM_W-1:0]     out_face_number,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rdfc_pkg::BOUND_W-1:0]        cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                               state_r, state_nxt;
  logic [rdfc_pkg::BIT_CNT_W-1:0]       bit_cnt_r;
  logic [rdfc_pkg::SCAN_CNT_W-1:0]      scan_cnt_r;
  logic [rdfc_pkg::SCAN_CNT_W-1:0]      n_faces;
  logic                                 scan_end;
  logic                                 in_acc;
  logic                                 out_free;

  logic [rdfc_pkg::BOUND_W-1:0]         rest_low_r;
  logic [rdfc_pkg::BOUND_W-1:0]         rest_high_r;
  logic [rdfc_pkg::FACE_CNT_W-1:0]      face_count_r;

  rdfc_pkg::vec3_t                      samp_r;
  rdfc_pkg::vec3_t                      hist_r [rdfc_pkg::HISTORY_LEN];
  rdfc_pkg::vec3_t                      face_tab_r [rdfc_pkg::MAX_FACES];
  logic                                 was_moving_r;

  logic                                 out_valid_r;
  logic                                 out_rest_r;
  logic [rdfc_pkg::FACE_NUM_W-1:0]      out_face_r;

  rdfc_pkg::lane_ctl_t                  lane_ctl;
  rdfc_pkg::dec_ctl_t                   dec_ctl;
  logic [2:0]                           samp_bits;
  logic signed [rdfc_pkg::DOT_W-1:0]    hist_dot [rdfc_pkg::HISTORY_LEN];
  logic signed [rdfc_pkg::DOT_W-1:0]    face_dot [rdfc_pkg::MAX_FACES];
  logic                                 rest;
  logic [rdfc_pkg::FACE_NUM_W-1:0]      face_num;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // face count saturated to the table size
  assign n_faces = (32'(face_count_r) > 32'(rdfc_pkg::MAX_FACES)) ?
                   rdfc_pkg::SCAN_CNT_W'(rdfc_pkg::MAX_FACES) :
                   rdfc_pkg::SCAN_CNT_W'(face_count_r);
  assign scan_end = ({1'b0, scan_cnt_r} + (rdfc_pkg::SCAN_CNT_W + 1)'(1)) >=
                    {1'b0, n_faces};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && in_kind == rdfc_pkg::KIND_SAMPLE) state_nxt = ST_MUL;
      ST_MUL:  if (bit_cnt_r == rdfc_pkg::BIT_CNT_W'(rdfc_pkg::VEC_W - 1)) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_end) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      bit_cnt_r  <= '0;
      scan_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MUL) begin
        bit_cnt_r <= bit_cnt_r + rdfc_pkg::BIT_CNT_W'(1);
      end else begin
        bit_cnt_r <= '0;
      end
      if (state_r == ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + rdfc_pkg::SCAN_CNT_W'(1);
      end else begin
        scan_cnt_r <= '0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_low_r   <= rdfc_pkg::REST_LOW_RST;
      rest_high_r  <= rdfc_pkg::REST_HIGH_RST;
      face_count_r <= rdfc_pkg::FACE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rdfc_pkg::CFG_REST_LOW:   rest_low_r   <= cfg_data;
        rdfc_pkg::CFG_REST_HIGH:  rest_high_r  <= cfg_data;
        rdfc_pkg::CFG_FACE_COUNT: face_count_r <= cfg_data[rdfc_pkg::FACE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sample rotates one bit per cycle and is whole again after the multiply
  always_ff @(posedge clk) begin
    if (in_acc && in_kind == rdfc_pkg::KIND_SAMPLE) begin
      samp_r <= '{x: in_vec_x, y: in_vec_y, z: in_vec_z};
    end else if (state_r == ST_MUL) begin
      samp_r <= '{x: {samp_r.x[0], samp_r.x[rdfc_pkg::VEC_W-1:1]},
                  y: {samp_r.y[0], samp_r.y[rdfc_pkg::VEC_W-1:1]},
                  z: {samp_r.z[0], samp_r.z[rdfc_pkg::VEC_W-1:1]}};
    end
  end

  assign samp_bits = {samp_r.z[0], samp_r.y[0], samp_r.x[0]};

  always_ff @(posedge clk) begin
    if (in_acc && in_kind == rdfc_pkg::KIND_FACE &&
        32'(in_face_slot) < 32'(rdfc_pkg::MAX_FACES)) begin
      face_tab_r[rdfc_pkg::FACE_IDX_W'(in_face_slot)] <=
        '{x: in_vec_x, y: in_vec_y, z: in_vec_z};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rdfc_pkg::HISTORY_LEN; i++) begin
        hist_r[i] <= '0;
      end
      was_moving_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      hist_r[0] <= samp_r;
      for (int i = 1; i < rdfc_pkg::HISTORY_LEN; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      was_moving_r <= !rest;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_rest_r <= rest && was_moving_r;
      out_face_r <= face_num;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_came_to_rest = out_rest_r;
  assign out_face_number  = out_face_r;

  assign lane_ctl.en    = (state_r == ST_MUL);
  assign lane_ctl.first = (bit_cnt_r == '0);
  assign lane_ctl.last  = (bit_cnt_r == rdfc_pkg::BIT_CNT_W'(rdfc_pkg::VEC_W - 1));

  assign dec_ctl.clear  = (state_r == ST_MUL) && lane_ctl.last;
  assign dec_ctl.en     = (state_r == ST_SCAN);
  assign dec_ctl.active = (scan_cnt_r < n_faces);
  assign dec_ctl.idx    = scan_cnt_r;

  for (genvar g = 0; g < rdfc_pkg::HISTORY_LEN; g++) begin : g_hist_lane
    rdfc_dot_lane u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .bits (samp_bits),
      .vec  (hist_r[g]),
      .dot  (hist_dot[g])
    );
  end

  for (genvar g = 0; g < rdfc_pkg::MAX_FACES; g++) begin : g_face_lane
    rdfc_dot_lane u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .bits (samp_bits),
      .vec  (face_tab_r[g]),
      .dot  (face_dot[g])
    );
  end

  rdfc_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (dec_ctl),
    .rest_low  (rest_low_r),
    .rest_high (rest_high_r),
    .hist_dot  (hist_dot),
    .face_dot  (face_dot),
    .rest      (rest),
    .face_num  (face_num)
  );

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a finished sample");

  a_mul_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && state_nxt == ST_SCAN) |->
      bit_cnt_r == rdfc_pkg::BIT_CNT_W'(rdfc_pkg::VEC_W - 1))
    else $error("multiply left before all sample bits were used");

  a_hist_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DONE) |=> $stable(hist_r[0]))
    else $error("history changed outside the result cycle");

  a_pulse_clears_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rest_r) |-> !was_moving_r)
    else $error("came_to_rest pending while motion flag is set");
`endif

endmodule

FILE: rtl/rdfc_dot_lane.sv
// one bit-serial dot product lane: sample bits arrive lsb first, one per axis per cycle
// depends on rdfc_pkg
`timescale 1ns / 1ps

module rdfc_dot_lane (
  input  logic                             clk,
  input  rdfc_pkg::lane_ctl_t              ctl,
  input  logic [2:0]                       bits,
  input  rdfc_pkg::vec3_t                  vec,
  output logic signed [rdfc_pkg::DOT_W-1:0] dot
);

  logic signed [rdfc_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [rdfc_pkg::LO_W-1:0]         lo_r, lo_nxt;
  logic signed [rdfc_pkg::P_W-1:0]   part;
  logic signed [rdfc_pkg::ACC_W-1:0] base;
  logic signed [rdfc_pkg::ACC_W-1:0] part_ext;
  logic signed [rdfc_pkg::ACC_W-1:0] sum;

  function automatic logic signed [rdfc_pkg::P_W-1:0] sel_ext(
    input logic b, input logic signed [rdfc_pkg::VEC_W-1:0] v);
    logic signed [rdfc_pkg::P_W-1:0] r;
    r = {{(rdfc_pkg::P_W - rdfc_pkg::VEC_W){v[rdfc_pkg::VEC_W-1]}}, v};
    return b ? r : '0;
  endfunction

  always_comb begin
    part = sel_ext(bits[0], vec.x) + sel_ext(bits[1], vec.y) + sel_ext(bits[2], vec.z);
    part_ext = {{(rdfc_pkg::ACC_W - rdfc_pkg::P_W){part[rdfc_pkg::P_W-1]}}, part};
    base = ctl.first ? '0 : acc_r;
    // sign bit of the sample carries negative weight
    sum = ctl.last ? (base - part_ext) : (base + part_ext);
    if (ctl.last) begin
      acc_nxt = sum;
      lo_nxt  = lo_r;
    end else begin
      acc_nxt = sum >>> 1;
      lo_nxt  = {sum[0], lo_r[rdfc_pkg::LO_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign dot = {acc_r, lo_r};

endmodule

FILE: rtl/rdfc_decide.sv
// rest window check over the history dot products and sequential argmax over face dots
// depends on rdfc_pkg
`timescale 1ns / 1ps

module rdfc_decide (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rdfc_pkg::dec_ctl_t                  ctl,
  input  logic [rdfc_pkg::BOUND_W-1:0]        rest_low,
  input  logic [rdfc_pkg::BOUND_W-1:0]        rest_high,
  input  logic signed [rdfc_pkg::DOT_W-1:0]   hist_dot [rdfc_pkg::HISTORY_LEN],
  input  logic signed [rdfc_pkg::DOT_W-1:0]   face_dot [rdfc_pkg::MAX_FACES],
  output logic                                rest,
  output logic [rdfc_pkg::FACE_NUM_W-1:0]     face_num
);

  logic                                rest_r;
  logic signed [rdfc_pkg::DOT_W-1:0]   best_r, best_nxt;
  logic [rdfc_pkg::FACE_NUM_W-1:0]     face_r, face_nxt;
  logic [rdfc_pkg::HISTORY_LEN-1:0]    in_win;
  logic signed [rdfc_pkg::DOT_W-1:0]   lo_ext, hi_ext;
  logic signed [rdfc_pkg::DOT_W-1:0]   cand;
  logic [rdfc_pkg::SCAN_CNT_W:0]       idx_p1;

  always_comb begin
    lo_ext = $signed({{(rdfc_pkg::DOT_W - rdfc_pkg::BOUND_W){1'b0}}, rest_low});
    hi_ext = $signed({{(rdfc_pkg::DOT_W - rdfc_pkg::BOUND_W){1'b0}}, rest_high});
    for (int i = 0; i < rdfc_pkg::HISTORY_LEN; i++) begin
      in_win[i] = (hist_dot[i] > lo_ext) && (hist_dot[i] < hi_ext);
    end
  end

  always_comb begin
    cand     = face_dot[ctl.idx[rdfc_pkg::FACE_IDX_W-1:0]];
    idx_p1   = {1'b0, ctl.idx} + (rdfc_pkg::SCAN_CNT_W + 1)'(1);
    best_nxt = best_r;
    face_nxt = face_r;
    if (ctl.clear) begin
      best_nxt = '0;
      face_nxt = '0;
    end else if (ctl.en && ctl.active && (cand > best_r)) begin
      // first strictly largest wins, so ties keep the earlier face
      best_nxt = cand;
      face_nxt = rdfc_pkg::FACE_NUM_W'(idx_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= 1'b0;
    end else if (ctl.en) begin
      rest_r <= &in_win;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    face_r <= face_nxt;
  end

  assign rest     = rest_r;
  assign face_num = face_r;

endmodule
